// File: design/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, operation and status codes, and controller commands for the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 9;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_R = 2'd0,
    CMD_POP_L  = 2'd1,
    CMD_POP_R  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic load;    // result register loaded this cycle
  } dp_cmd_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) res = '0;
    else                          res = idx + 1'b1;
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0) res = IDX_W'(DEPTH - 1);
    else           res = idx - 1'b1;
    return res;
  endfunction

endpackage
`default_nettype wire

// File: design/dq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channels of the double-ended queue: request and result.
// ----------------------------------------------------------------------------
interface dq_in_if;
  import dq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] item;

  modport source (output valid, output cmd, output item, input ready);
  modport sink   (input valid, input cmd, input item, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] popped_value;
  logic [DATA_W-1:0] left_value;
  logic [DATA_W-1:0] right_value;
  logic              is_empty;
  logic [OCC_W-1:0]  occupancy;
  logic [STAT_W-1:0] status;

  modport source (output valid, output popped_value, output left_value,
                  output right_value, output is_empty, output occupancy,
                  output status, input ready);
  modport sink   (input valid, input popped_value, input left_value,
                  input right_value, input is_empty, input occupancy,
                  input status, output ready);
endinterface
`default_nettype wire

// File: design/dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: takes a request, then folds the store read into the result
// register once the result side has room.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dq_pkg::dp_cmd_t      dp_cmd
);
  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, load;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load      = (state_r == S_LOAD) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign dp_cmd    = '{accept: accept, load: load};

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait here while the previous result is still held
        if (load) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/dq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_dpath
// Ring store, end pointers, cached end values and the result register.
// ----------------------------------------------------------------------------
module dq_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dq_pkg::dp_cmd_t             dp_cmd,
  input  wire logic [dq_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [dq_pkg::DATA_W-1:0]   in_item,
  output logic [dq_pkg::DATA_W-1:0]        out_popped_value,
  output logic [dq_pkg::DATA_W-1:0]        out_left_value,
  output logic [dq_pkg::DATA_W-1:0]        out_right_value,
  output logic                             out_is_empty,
  output logic [dq_pkg::OCC_W-1:0]         out_occupancy,
  output logic [dq_pkg::STAT_W-1:0]        out_status
);
  import dq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // pointer state
  logic [IDX_W-1:0]  left_r, left_nxt;
  logic [IDX_W-1:0]  ridx_r, ridx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // cached end values, valid only while not empty
  logic [DATA_W-1:0] lval_r, lval_nxt;
  logic [DATA_W-1:0] rval_r, rval_nxt;

  // per-request scratch
  logic [DATA_W-1:0] popped_r, popped_nxt;
  status_t           status_r, status_nxt;
  logic              fix_left_r, fix_left_nxt;
  logic              fix_right_r, fix_right_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic              empty, full;
  cmd_t              op;
  logic [DATA_W-1:0] left_new, right_new;

  // result register
  logic [DATA_W-1:0] res_popped_r, res_left_r, res_right_r;
  logic              res_empty_r;
  logic [OCC_W-1:0]  res_occ_r;
  logic [STAT_W-1:0] res_status_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign op    = cmd_t'(in_cmd);

  always_comb begin
    left_nxt      = left_r;
    ridx_nxt      = ridx_r;
    count_nxt     = count_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    fix_left_nxt  = fix_left_r;
    fix_right_nxt = fix_right_r;
    wr_en         = 1'b0;
    wr_addr       = empty ? left_r : idx_inc(ridx_r);
    rd_addr       = '0;
    if (dp_cmd.accept) begin
      popped_nxt    = '0;
      status_nxt    = ST_OK;
      fix_left_nxt  = 1'b0;
      fix_right_nxt = 1'b0;
      unique case (op)
        CMD_PUSH_R: begin
          if (full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            ridx_nxt  = wr_addr;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP_L: begin
          if (empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            popped_nxt = lval_r;
            count_nxt  = count_r - 1'b1;
            if (count_r == CNT_W'(1)) begin
              left_nxt = '0;
              ridx_nxt = '0;
            end else begin
              left_nxt     = idx_inc(left_r);
              rd_addr      = idx_inc(left_r);
              fix_left_nxt = 1'b1;
            end
          end
        end
        CMD_POP_R: begin
          if (empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            popped_nxt = rval_r;
            count_nxt  = count_r - 1'b1;
            if (count_r == CNT_W'(1)) begin
              left_nxt = '0;
              ridx_nxt = '0;
            end else begin
              ridx_nxt      = idx_dec(ridx_r);
              rd_addr       = idx_dec(ridx_r);
              fix_right_nxt = 1'b1;
            end
          end
        end
        CMD_QUERY: begin
        end
        default: begin
        end
      endcase
    end
  end

  // new end values once the store read is back
  assign left_new  = fix_left_r  ? rd_data_r : lval_r;
  assign right_new = fix_right_r ? rd_data_r : rval_r;

  always_comb begin
    lval_nxt = lval_r;
    rval_nxt = rval_r;
    if (wr_en) begin
      rval_nxt = in_item;
      if (empty) lval_nxt = in_item;
    end
    if (dp_cmd.load) begin
      lval_nxt = left_new;
      rval_nxt = right_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_item;
    if (dp_cmd.accept) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      ridx_r      <= '0;
      count_r     <= '0;
      status_r    <= ST_OK;
      fix_left_r  <= 1'b0;
      fix_right_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      ridx_r      <= ridx_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      fix_left_r  <= fix_left_nxt;
      fix_right_r <= fix_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lval_r   <= lval_nxt;
    rval_r   <= rval_nxt;
    popped_r <= popped_nxt;
    if (dp_cmd.load) begin
      res_popped_r <= popped_r;
      res_left_r   <= empty ? '0 : left_new;
      res_right_r  <= empty ? '0 : right_new;
      res_empty_r  <= empty;
      res_occ_r    <= OCC_W'(count_r);
      res_status_r <= status_r;
    end
  end

  assign out_popped_value = res_popped_r;
  assign out_left_value   = res_left_r;
  assign out_right_value  = res_right_r;
  assign out_is_empty     = res_empty_r;
  assign out_occupancy    = res_occ_r;
  assign out_status       = res_status_r;

endmodule
`default_nettype wire

// File: design/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque in a ring store: push right, pop left, pop right, query.
// ----------------------------------------------------------------------------
// Each request returns exactly one result carrying the popped value, both end
// values, the occupancy, an empty flag and a status (overflow on a push into a
// full store, underflow on a pop from an empty one). A request first moves the
// pointers and accesses the single-port-read ring store, then folds the read
// data into the cached end values and loads the result register; the next
// request is not taken until that load is done. A new request is taken while
// the previous result still waits on the output; the load stalls only while
// that result has not been taken. No clearing pass runs after reset.
module double_ended_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  dq_in_if.sink     in_req,
  dq_out_if.source  out_rsp
);
  import dq_pkg::*;

  dp_cmd_t dp_cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .dp_cmd    (dp_cmd)
  );

  dq_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .dp_cmd           (dp_cmd),
    .in_cmd           (in_req.cmd),
    .in_item          (in_req.item),
    .out_popped_value (out_rsp.popped_value),
    .out_left_value   (out_rsp.left_value),
    .out_right_value  (out_rsp.right_value),
    .out_is_empty     (out_rsp.is_empty),
    .out_occupancy    (out_rsp.occupancy),
    .out_status       (out_rsp.status)
  );

endmodule
`default_nettype wire
